// ----- src/lps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lps_pkg
// shared types and constants of the l-piece subdivision core
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int FIELD_W     = 10;
    localparam int RULE_W      = 4;
    localparam int N_SLOT      = 4;   // table lookups per request, one table copy each
    localparam int N_COORD     = 8;   // coordinates of the two result pieces
    localparam int MAX_DIM_DEF = 1024;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // subdivision rule codes
    localparam logic [RULE_W-1:0] RULE_B1 = 4'd0;
    localparam logic [RULE_W-1:0] RULE_B2 = 4'd1;
    localparam logic [RULE_W-1:0] RULE_B3 = 4'd2;
    localparam logic [RULE_W-1:0] RULE_B4 = 4'd3;
    localparam logic [RULE_W-1:0] RULE_B5 = 4'd4;
    localparam logic [RULE_W-1:0] RULE_B6 = 4'd5;
    localparam logic [RULE_W-1:0] RULE_B7 = 4'd6;
    localparam logic [RULE_W-1:0] RULE_B8 = 4'd7;
    localparam logic [RULE_W-1:0] RULE_B9 = 4'd8;

    // operation codes
    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_SUBDIVIDE = 1'b1;

    // where a result coordinate comes from
    typedef enum logic [2:0] {
        SRC_DIRECT = 3'd0,
        SRC_SLOT0  = 3'd1,
        SRC_SLOT1  = 3'd2,
        SRC_SLOT2  = 3'd3,
        SRC_SLOT3  = 3'd4
    } t_src;

    // classified request travelling from front to back
    typedef struct packed {
        logic                                is_write;
        logic [FIELD_W-1:0]                  wr_index;
        logic                                wr_in_range;
        logic [FIELD_W-1:0]                  wr_value;
        logic                                bad;
        logic [N_SLOT-1:0][FIELD_W-1:0]      diff;
        logic [N_SLOT-1:0]                   diff_ok;
        t_src [N_COORD-1:0]                  src;
        logic [N_COORD-1:0][FIELD_W-1:0]     direct;
    } t_entry;

    // result payload, coordinates in port order
    typedef struct packed {
        logic [N_COORD-1:0][FIELD_W-1:0] coord;
        logic                            bad;
    } t_result;

endpackage
`default_nettype wire

// ----- src/lps_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lps_front
// classifies a request: picks the rule's operand pairs, forms the
// differences and flags, and marks where each coordinate comes from
// ----------------------------------------------------------------------------
module lps_front #(
    parameter int MAX_DIM = lps_pkg::MAX_DIM_DEF
) (
    input  wire logic                              i_operation,
    input  wire logic [lps_pkg::RULE_W-1:0]        i_rule,
    input  wire logic [lps_pkg::FIELD_W-1:0]       i_outer_x,
    input  wire logic [lps_pkg::FIELD_W-1:0]       i_outer_y,
    input  wire logic [lps_pkg::FIELD_W-1:0]       i_inner_x,
    input  wire logic [lps_pkg::FIELD_W-1:0]       i_inner_y,
    input  wire logic [lps_pkg::FIELD_W-1:0]       i_cut_x,
    input  wire logic [lps_pkg::FIELD_W-1:0]       i_cut_y,
    input  wire logic [lps_pkg::FIELD_W-1:0]       i_cut_extra,
    input  wire logic [lps_pkg::FIELD_W-1:0]       i_table_index,
    input  wire logic [lps_pkg::FIELD_W-1:0]       i_table_value,
    output lps_pkg::t_entry                        o_entry,
    output logic                                   o_keep
);

    logic [lps_pkg::N_SLOT-1:0][lps_pkg::FIELD_W-1:0] w_a;
    logic [lps_pkg::N_SLOT-1:0][lps_pkg::FIELD_W-1:0] w_b;
    logic [lps_pkg::N_SLOT-1:0][lps_pkg::FIELD_W:0]   w_sub;
    lps_pkg::t_src [lps_pkg::N_COORD-1:0]             w_src;
    logic [lps_pkg::N_COORD-1:0][lps_pkg::FIELD_W-1:0] w_dir;
    logic                                             w_rule_ok;

    // operand pairs and coordinate sources per rule
    always_comb begin
        w_a       = '0;
        w_b       = '0;
        w_src     = {lps_pkg::N_COORD{lps_pkg::SRC_DIRECT}};
        w_dir     = '0;
        w_rule_ok = 1'b1;
        unique case (i_rule)
            lps_pkg::RULE_B1: begin
                w_dir[0] = i_inner_x;
                w_src[1] = lps_pkg::SRC_SLOT0; w_a[0] = i_outer_y; w_b[0] = i_cut_y;
                w_dir[2] = i_cut_x;
                w_src[3] = lps_pkg::SRC_SLOT1; w_a[1] = i_outer_y; w_b[1] = i_inner_y;
                w_dir[4] = i_outer_x;
                w_dir[5] = i_inner_y;
                w_src[6] = lps_pkg::SRC_SLOT2; w_a[2] = i_outer_x; w_b[2] = i_cut_x;
                w_dir[7] = i_cut_y;
            end
            lps_pkg::RULE_B2: begin
                w_dir[0] = i_inner_x;
                w_src[1] = lps_pkg::SRC_SLOT0; w_a[0] = i_outer_y; w_b[0] = i_inner_y;
                w_src[2] = lps_pkg::SRC_SLOT1; w_a[1] = i_inner_x; w_b[1] = i_cut_x;
                w_src[3] = lps_pkg::SRC_SLOT2; w_a[2] = i_outer_y; w_b[2] = i_cut_y;
                w_dir[4] = i_outer_x;
                w_dir[5] = i_cut_y;
                w_dir[6] = i_cut_x;
                w_dir[7] = i_inner_y;
            end
            lps_pkg::RULE_B3: begin
                w_dir[0] = i_outer_x;
                w_dir[1] = i_outer_y;
                w_dir[2] = i_cut_x;
                w_dir[3] = i_cut_y;
                w_src[4] = lps_pkg::SRC_SLOT0; w_a[0] = i_outer_x; w_b[0] = i_cut_x;
                w_src[5] = lps_pkg::SRC_SLOT1; w_a[1] = i_outer_y; w_b[1] = i_cut_y;
                w_src[6] = lps_pkg::SRC_SLOT2; w_a[2] = i_inner_x; w_b[2] = i_cut_x;
                w_src[7] = lps_pkg::SRC_SLOT3; w_a[3] = i_inner_y; w_b[3] = i_cut_y;
            end
            lps_pkg::RULE_B4: begin
                w_dir[0] = i_cut_x;
                w_dir[1] = i_outer_y;
                w_dir[2] = i_inner_x;
                w_dir[3] = i_cut_y;
                w_src[4] = lps_pkg::SRC_SLOT0; w_a[0] = i_outer_x; w_b[0] = i_inner_x;
                w_dir[5] = i_inner_y;
                w_src[6] = lps_pkg::SRC_SLOT1; w_a[1] = i_outer_x; w_b[1] = i_cut_x;
                w_src[7] = lps_pkg::SRC_SLOT2; w_a[2] = i_inner_y; w_b[2] = i_cut_y;
            end
            lps_pkg::RULE_B5: begin
                w_dir[0] = i_inner_x;
                w_dir[1] = i_outer_y;
                w_dir[2] = i_cut_x;
                w_src[3] = lps_pkg::SRC_SLOT0; w_a[0] = i_outer_y; w_b[0] = i_cut_y;
                w_src[4] = lps_pkg::SRC_SLOT1; w_a[1] = i_outer_x; w_b[1] = i_cut_x;
                w_dir[5] = i_inner_y;
                w_src[6] = lps_pkg::SRC_SLOT2; w_a[2] = i_outer_x; w_b[2] = i_inner_x;
                w_dir[7] = i_cut_y;
            end
            lps_pkg::RULE_B6: begin
                w_dir[0] = i_cut_extra;
                w_dir[1] = i_outer_y;
                w_dir[2] = i_cut_x;
                w_src[3] = lps_pkg::SRC_SLOT0; w_a[0] = i_outer_y; w_b[0] = i_cut_y;
                w_src[4] = lps_pkg::SRC_SLOT1; w_a[1] = i_outer_x; w_b[1] = i_cut_x;
                w_dir[5] = i_outer_y;
                w_src[6] = lps_pkg::SRC_SLOT2; w_a[2] = i_outer_x; w_b[2] = i_cut_extra;
                w_dir[7] = i_cut_y;
            end
            lps_pkg::RULE_B7: begin
                w_dir[0] = i_outer_x;
                w_src[1] = lps_pkg::SRC_SLOT0; w_a[0] = i_outer_y; w_b[0] = i_cut_y;
                w_dir[2] = i_cut_x;
                w_src[3] = lps_pkg::SRC_SLOT1; w_a[1] = i_outer_y; w_b[1] = i_cut_extra;
                w_dir[4] = i_outer_x;
                w_dir[5] = i_cut_extra;
                w_src[6] = lps_pkg::SRC_SLOT2; w_a[2] = i_outer_x; w_b[2] = i_cut_x;
                w_dir[7] = i_cut_y;
            end
            lps_pkg::RULE_B8: begin
                w_dir[0] = i_inner_x;
                w_dir[1] = i_outer_y;
                w_dir[2] = i_cut_x;
                w_src[3] = lps_pkg::SRC_SLOT0; w_a[0] = i_outer_y; w_b[0] = i_cut_y;
                w_src[4] = lps_pkg::SRC_SLOT1; w_a[1] = i_outer_x; w_b[1] = i_cut_x;
                w_dir[5] = i_cut_y;
                w_src[6] = lps_pkg::SRC_SLOT2; w_a[2] = i_inner_x; w_b[2] = i_cut_x;
                w_dir[7] = i_inner_y;
            end
            lps_pkg::RULE_B9: begin
                w_dir[0] = i_cut_x;
                w_src[1] = lps_pkg::SRC_SLOT0; w_a[0] = i_outer_y; w_b[0] = i_cut_y;
                w_dir[2] = i_inner_x;
                w_src[3] = lps_pkg::SRC_SLOT1; w_a[1] = i_inner_y; w_b[1] = i_cut_y;
                w_dir[4] = i_outer_x;
                w_dir[5] = i_inner_y;
                w_src[6] = lps_pkg::SRC_SLOT2; w_a[2] = i_outer_x; w_b[2] = i_cut_x;
                w_dir[7] = i_cut_y;
            end
            default: begin
                w_rule_ok = 1'b0;
            end
        endcase
    end

    // one subtractor per slot, the borrow marks a negative difference
    always_comb begin
        for (int k = 0; k < lps_pkg::N_SLOT; k++) begin
            w_sub[k] = {1'b0, w_a[k]} - {1'b0, w_b[k]};
        end
    end

    always_comb begin
        o_entry             = '0;
        o_entry.is_write    = (i_operation == lps_pkg::OP_WRITE);
        o_entry.wr_index    = i_table_index;
        o_entry.wr_in_range = (int'(i_table_index) < MAX_DIM);
        o_entry.wr_value    = i_table_value;
        o_entry.src         = w_src;
        o_entry.direct      = w_dir;
        for (int k = 0; k < lps_pkg::N_SLOT; k++) begin
            o_entry.diff[k]    = w_sub[k][lps_pkg::FIELD_W-1:0];
            o_entry.diff_ok[k] = (int'(w_sub[k][lps_pkg::FIELD_W-1:0]) < MAX_DIM);
            if (w_sub[k][lps_pkg::FIELD_W]) begin
                o_entry.bad = 1'b1;
            end
        end
        // an unknown rule drops a subdivide request, writes always go on
        o_keep = o_entry.is_write || w_rule_ok;
    end

endmodule
`default_nettype wire

// ----- src/lps_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lps_queue
// short fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module lps_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire lps_pkg::t_entry i_entry,
    output logic                 o_full,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output lps_pkg::t_entry      o_entry
);

    lps_pkg::t_entry                r_mem [lps_pkg::QUEUE_DEPTH];
    logic [lps_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [lps_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [lps_pkg::QCNT_W-1:0]     r_count;
    logic [lps_pkg::QCNT_W-1:0]     n_count;

    assign o_full  = (r_count == lps_pkg::QCNT_W'(lps_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

// ----- src/lps_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lps_back
// executes requests: table writes into every copy, table reads of the
// four differences, result assembly and output register
// ----------------------------------------------------------------------------
module lps_back #(
    parameter int MAX_DIM = lps_pkg::MAX_DIM_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lps_pkg::t_entry i_q_entry,
    input  wire logic            i_q_empty,
    output logic                 o_pop,
    output logic                 o_stage_valid,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output lps_pkg::t_result     o_result
);

    localparam int AW = $clog2(MAX_DIM);

    logic w_out_ready;
    logic w_stage_ready;
    logic w_rd_en;
    logic w_wr_en;

    logic [lps_pkg::N_SLOT-1:0][lps_pkg::FIELD_W-1:0]  w_rd;
    logic                                              r_s1_valid;
    logic                                              r_s1_bad;
    lps_pkg::t_src [lps_pkg::N_COORD-1:0]              r_s1_src;
    logic [lps_pkg::N_COORD-1:0][lps_pkg::FIELD_W-1:0] r_s1_direct;
    logic [lps_pkg::N_SLOT-1:0]                        r_s1_ok;
    lps_pkg::t_result                                  n_result;
    lps_pkg::t_result                                  r_result;
    logic                                              r_out_valid;

    function automatic logic [lps_pkg::FIELD_W-1:0] pick(
        input lps_pkg::t_src                                      src,
        input logic [lps_pkg::FIELD_W-1:0]                        direct,
        input logic [lps_pkg::N_SLOT-1:0][lps_pkg::FIELD_W-1:0]   rd,
        input logic [lps_pkg::N_SLOT-1:0]                         ok
    );
        logic [lps_pkg::FIELD_W-1:0] v;
        v = '0;
        unique case (src)
            lps_pkg::SRC_DIRECT: v = direct;
            lps_pkg::SRC_SLOT0:  v = ok[0] ? rd[0] : '0;
            lps_pkg::SRC_SLOT1:  v = ok[1] ? rd[1] : '0;
            lps_pkg::SRC_SLOT2:  v = ok[2] ? rd[2] : '0;
            lps_pkg::SRC_SLOT3:  v = ok[3] ? rd[3] : '0;
            default:             v = '0;
        endcase
        return v;
    endfunction

    assign w_out_ready   = !r_out_valid || !i_out_stall;
    assign w_stage_ready = !r_s1_valid || w_out_ready;
    assign o_pop         = !i_q_empty && w_stage_ready;
    assign w_rd_en       = o_pop && !i_q_entry.is_write;
    assign w_wr_en       = o_pop && i_q_entry.is_write && i_q_entry.wr_in_range;

    // one table copy per lookup slot, all written alike
    for (genvar g = 0; g < lps_pkg::N_SLOT; g++) begin : g_tab
        logic [lps_pkg::FIELD_W-1:0] r_tab [MAX_DIM];
        logic [lps_pkg::FIELD_W-1:0] r_rd_q;

        always_ff @(posedge i_clk) begin
            if (w_wr_en) begin
                r_tab[AW'(i_q_entry.wr_index)] <= i_q_entry.wr_value;
            end
            if (w_rd_en) begin
                r_rd_q <= r_tab[AW'(i_q_entry.diff[g])];
            end
        end

        assign w_rd[g] = r_rd_q;
    end

    // lookup stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_stage_ready) begin
            r_s1_valid <= w_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_s1_bad    <= i_q_entry.bad;
            r_s1_src    <= i_q_entry.src;
            r_s1_direct <= i_q_entry.direct;
            r_s1_ok     <= i_q_entry.diff_ok;
        end
    end

    // assembly, a negative difference clears the whole result
    always_comb begin
        n_result.bad = r_s1_bad;
        for (int k = 0; k < lps_pkg::N_COORD; k++) begin
            n_result.coord[k] = r_s1_bad ? '0
                              : pick(r_s1_src[k], r_s1_direct[k], w_rd, r_s1_ok);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_s1_valid) begin
            r_result <= n_result;
        end
    end

    assign o_stage_valid = r_s1_valid;
    assign o_out_valid   = r_out_valid;
    assign o_result      = r_result;

endmodule
`default_nettype wire

// ----- src/l_piece_subdivision_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// l_piece_subdivision_core
// splits an l-shaped piece at a cut point into two l-pieces by rules b1..b9
// ----------------------------------------------------------------------------
// The core takes one request per clock while o_in_stall is low and gives
// one result per subdivide request; table writes and requests with a rule
// code above eight give no result. The rate of one request a cycle is set
// by the lookup stage: each of the up to four differences a rule forms has
// its own copy of the normalisation table (MAX_DIM words of 10 bits each),
// so all lookups of a request happen in the same memory read cycle, and a
// write request updates every copy at once.
// A four-deep queue separates the classifying front from the executing back,
// so requests keep flowing in while the output is stalled, until it is full.
// The table has no reset and no clearing pass: a subdivide request must only
// reach entries written before it. Writes at an index of MAX_DIM or above are
// dropped, and a difference of MAX_DIM or above normalises to zero.
// ----------------------------------------------------------------------------
module l_piece_subdivision_core #(
    parameter int MAX_DIM = lps_pkg::MAX_DIM_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_operation,
    input  wire logic [lps_pkg::RULE_W-1:0]  i_rule,
    input  wire logic [lps_pkg::FIELD_W-1:0] i_outer_x,
    input  wire logic [lps_pkg::FIELD_W-1:0] i_outer_y,
    input  wire logic [lps_pkg::FIELD_W-1:0] i_inner_x,
    input  wire logic [lps_pkg::FIELD_W-1:0] i_inner_y,
    input  wire logic [lps_pkg::FIELD_W-1:0] i_cut_x,
    input  wire logic [lps_pkg::FIELD_W-1:0] i_cut_y,
    input  wire logic [lps_pkg::FIELD_W-1:0] i_cut_extra,
    input  wire logic [lps_pkg::FIELD_W-1:0] i_table_index,
    input  wire logic [lps_pkg::FIELD_W-1:0] i_table_value,
    // result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [lps_pkg::FIELD_W-1:0]      o_first_outer_x,
    output logic [lps_pkg::FIELD_W-1:0]      o_first_outer_y,
    output logic [lps_pkg::FIELD_W-1:0]      o_first_inner_x,
    output logic [lps_pkg::FIELD_W-1:0]      o_first_inner_y,
    output logic [lps_pkg::FIELD_W-1:0]      o_second_outer_x,
    output logic [lps_pkg::FIELD_W-1:0]      o_second_outer_y,
    output logic [lps_pkg::FIELD_W-1:0]      o_second_inner_x,
    output logic [lps_pkg::FIELD_W-1:0]      o_second_inner_y,
    output logic                             o_bad_cut
);

    lps_pkg::t_entry  w_entry;
    lps_pkg::t_entry  w_q_entry;
    lps_pkg::t_result w_result;
    logic             w_keep;
    logic             w_push;
    logic             w_q_full;
    logic             w_q_empty;
    logic             w_pop;
    logic             w_stage_valid;

    // front: classify the request combinationally on the way into the queue
    lps_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_operation   (i_operation),
        .i_rule        (i_rule),
        .i_outer_x     (i_outer_x),
        .i_outer_y     (i_outer_y),
        .i_inner_x     (i_inner_x),
        .i_inner_y     (i_inner_y),
        .i_cut_x       (i_cut_x),
        .i_cut_y       (i_cut_y),
        .i_cut_extra   (i_cut_extra),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .o_entry       (w_entry),
        .o_keep        (w_keep)
    );

    // stall only on a full queue, dropped requests still need a free slot
    assign o_in_stall = w_q_full;
    assign w_push     = i_in_valid && !w_q_full && w_keep;

    lps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .i_pop   (w_pop),
        .o_entry (w_q_entry)
    );

    // back: table writes, lookups, assembly and output register
    lps_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_entry     (w_q_entry),
        .i_q_empty     (w_q_empty),
        .o_pop         (w_pop),
        .o_stage_valid (w_stage_valid),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result      (w_result)
    );

    assign o_first_outer_x  = w_result.coord[0];
    assign o_first_outer_y  = w_result.coord[1];
    assign o_first_inner_x  = w_result.coord[2];
    assign o_first_inner_y  = w_result.coord[3];
    assign o_second_outer_x = w_result.coord[4];
    assign o_second_outer_y = w_result.coord[5];
    assign o_second_inner_x = w_result.coord[6];
    assign o_second_inner_y = w_result.coord[7];
    assign o_bad_cut        = w_result.bad;

    // a flagged result carries no coordinates
    a_bad_cut_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_cut) |->
            (o_first_outer_x == '0 && o_first_outer_y == '0 &&
             o_first_inner_x == '0 && o_first_inner_y == '0 &&
             o_second_outer_x == '0 && o_second_outer_y == '0 &&
             o_second_inner_x == '0 && o_second_inner_y == '0))
        else $error("flagged result with nonzero coordinates");

    // a new result always comes out of the lookup stage
    a_out_from_stage : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_stage_valid))
        else $error("result appeared without a lookup");

    // reset empties the queue and the output register
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("core not empty after reset");

endmodule
`default_nettype wire
